[sv/pvp_pkg.sv]
// ----------------------------------------------------------------------------
// pvp_pkg: shared types and constants of the viewport projection block
// Fixed-point formats, payload words, camera registers, queue entry layout.
// ----------------------------------------------------------------------------
`default_nettype none

package pvp_pkg;

  // fixed-point format of every coordinate and vector component
  localparam int CoordBits = 20;
  localparam int FracBits  = 12;

  // configuration port
  localparam int NumRegs  = 4;
  localparam int RegBits  = 3 * CoordBits;
  localparam int DataBits = 64;
  localparam int AddrBits = 5;

  // default depth of the queue between front and back
  localparam int FifoDepth = 4;

  // datapath widths
  localparam int PntW  = CoordBits + 1;          // point minus eye
  localparam int MulW  = 2 * CoordBits + 1;      // one component product
  localparam int DotW  = 2 * CoordBits + 2;      // signed dot product
  localparam int MagW  = 2 * CoordBits + 1;      // magnitude of a dot product
  localparam int LenW  = 2 * CoordBits;          // squared length
  localparam int ProdW = MagW + LenW;            // magnitude times squared length
  localparam int DivW  = ProdW + CoordBits + FracBits + 2;

  typedef enum logic [1:0] {
    RegEye   = 2'd0,
    RegSight = 2'd1,
    RegRight = 2'd2,
    RegUp    = 2'd3
  } cfg_reg_e;

  typedef struct packed {
    logic signed [CoordBits-1:0] point_x;
    logic signed [CoordBits-1:0] point_y;
    logic signed [CoordBits-1:0] point_z;
  } point_t;

  typedef struct packed {
    logic                        visible;
    logic signed [CoordBits-1:0] view_u;
    logic signed [CoordBits-1:0] view_v;
  } proj_t;

  // packed vector, x in the low bits
  typedef struct packed {
    logic signed [CoordBits-1:0] z;
    logic signed [CoordBits-1:0] y;
    logic signed [CoordBits-1:0] x;
  } vec_t;

  typedef struct packed {
    vec_t eye;
    vec_t sight;
    vec_t right;
    vec_t up;
  } cam_t;

  // one classified word handed from front to back
  typedef struct packed {
    logic                   visible;
    logic signed [DotW-1:0] num_u;
    logic signed [DotW-1:0] num_v;
    logic [MagW-1:0]        depth;
    logic [LenW-1:0]        len2;
    logic [LenW-1:0]        len2_u;
    logic [LenW-1:0]        len2_v;
  } qent_t;

endpackage

`default_nettype wire

[sv/perspective_viewport_projection_top.sv]
// ----------------------------------------------------------------------------
// perspective_viewport_projection_top: pinhole camera viewport projection
// Projects one 3D point per word onto the viewport set up by the camera
// registers.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i/in_ready_o) carries one point per word; the
//   output channel (out_valid_o/out_ready_i) returns one projected word for
//   each, in order: visible flag and saturated view_u/view_v (zero if hidden).
//   Camera registers are written over the APB port at byte addresses 0, 8, 16
//   and 24 (eye, sight, right, up) while no word is in flight.
// Timing:
//   The path runs through two front stages, a queue pass, a magnitude stage,
//   two multiplier stages, one division stage per quotient bit and the
//   output register.
//   Throughput is one word per cycle unless stalled, set by the pipelined divider.
// Reset:
//   All valid flags and the queue clear; camera registers return to eye at the
//   origin, sight along +z, right along +x, up along +y, all unit length.
// Stall:
//   A stalled receiver freezes the back part; the front keeps accepting words
//   into the queue until it fills, then drops in_ready_o.
// ----------------------------------------------------------------------------
`default_nettype none

module perspective_viewport_projection_top #(
  parameter int FIFO_DEPTH = pvp_pkg::FifoDepth
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           in_valid_i,
  output logic                                in_ready_o,
  input  wire pvp_pkg::point_t                in_data_i,
  output logic                                out_valid_o,
  input  wire logic                           out_ready_i,
  output pvp_pkg::proj_t                      out_data_o,
  input  wire logic                           psel,
  input  wire logic                           penable,
  input  wire logic                           pwrite,
  input  wire logic [pvp_pkg::AddrBits-1:0]   paddr,
  input  wire logic [pvp_pkg::DataBits-1:0]   pwdata,
  output logic [pvp_pkg::DataBits-1:0]        prdata,
  output logic                                pready
);
  import pvp_pkg::*;

  localparam logic [RegBits-1:0] One = RegBits'(1) << FracBits;

  logic [RegBits-1:0] eye_q, sight_q, right_q, up_q;
  logic [1:0] reg_idx;
  logic wr_en;
  cam_t cam;
  logic q_full, q_push, q_pop, q_nonempty;
  qent_t q_wdata, q_rdata;

  assign pready  = 1'b1;
  assign reg_idx = paddr[AddrBits-1:AddrBits-2];
  assign wr_en   = psel && penable && pwrite && pready;

  // camera registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      eye_q   <= '0;
      sight_q <= One << (2 * CoordBits);
      right_q <= One;
      up_q    <= One << CoordBits;
    end else if (wr_en) begin
      case (reg_idx)
        RegEye:   eye_q   <= pwdata[RegBits-1:0];
        RegSight: sight_q <= pwdata[RegBits-1:0];
        RegRight: right_q <= pwdata[RegBits-1:0];
        RegUp:    up_q    <= pwdata[RegBits-1:0];
        default: ;
      endcase
    end
  end

  // read back
  always_comb begin
    case (reg_idx)
      RegEye:   prdata = DataBits'(eye_q);
      RegSight: prdata = DataBits'(sight_q);
      RegRight: prdata = DataBits'(right_q);
      RegUp:    prdata = DataBits'(up_q);
      default:  prdata = '0;
    endcase
  end

  assign cam.eye   = vec_t'(eye_q);
  assign cam.sight = vec_t'(sight_q);
  assign cam.right = vec_t'(right_q);
  assign cam.up    = vec_t'(up_q);

  pvp_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .cam_i       (cam),
    .q_full_i    (q_full),
    .push_o      (q_push),
    .push_data_o (q_wdata)
  );

  pvp_queue #(.DEPTH(FIFO_DEPTH)) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (q_push),
    .push_data_i (q_wdata),
    .full_o      (q_full),
    .pop_i       (q_pop),
    .nonempty_o  (q_nonempty),
    .pop_data_o  (q_rdata)
  );

  pvp_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .nonempty_i  (q_nonempty),
    .pop_data_i  (q_rdata),
    .pop_o       (q_pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

`default_nettype wire

[sv/pvp_front.sv]
// ----------------------------------------------------------------------------
// pvp_front: accept a point, form the dot products and classify visibility
// Two register stages: eye subtraction, then component products. The sums
// and the depth test feed the queue write directly.
// ----------------------------------------------------------------------------
`default_nettype none

module pvp_front (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_valid_i,
  output logic                in_ready_o,
  input  wire pvp_pkg::point_t in_data_i,
  input  wire pvp_pkg::cam_t  cam_i,
  input  wire logic           q_full_i,
  output logic                push_o,
  output pvp_pkg::qent_t      push_data_o
);
  import pvp_pkg::*;

  logic adv;
  logic v1_q, v2_q;
  logic signed [PntW-1:0] p_d [3];
  logic signed [PntW-1:0] p_q [3];
  logic signed [CoordBits-1:0] dv [3];
  logic signed [CoordBits-1:0] hv [3];
  logic signed [CoordBits-1:0] vv [3];
  logic signed [MulW-1:0] pd_q [3];
  logic signed [MulW-1:0] ph_q [3];
  logic signed [MulW-1:0] pv_q [3];
  logic signed [MulW-1:0] dd_q [3];
  logic signed [MulW-1:0] hh_q [3];
  logic signed [MulW-1:0] vvq_q [3];
  logic signed [DotW-1:0] z_s, len2_s, nu_s, nv_s, lu_s, lv_s;

  // advance the whole front while the queue has room
  assign adv        = !q_full_i;
  assign in_ready_o = adv;

  assign dv[0] = cam_i.sight.x;
  assign dv[1] = cam_i.sight.y;
  assign dv[2] = cam_i.sight.z;
  assign hv[0] = cam_i.right.x;
  assign hv[1] = cam_i.right.y;
  assign hv[2] = cam_i.right.z;
  assign vv[0] = cam_i.up.x;
  assign vv[1] = cam_i.up.y;
  assign vv[2] = cam_i.up.z;

  // subtract the eye position
  assign p_d[0] = PntW'(in_data_i.point_x) - PntW'(cam_i.eye.x);
  assign p_d[1] = PntW'(in_data_i.point_y) - PntW'(cam_i.eye.y);
  assign p_d[2] = PntW'(in_data_i.point_z) - PntW'(cam_i.eye.z);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else if (adv) begin
      v1_q <= in_valid_i;
      v2_q <= v1_q;
    end
  end

  // register the relative point, then the component products
  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        p_q[i]   <= p_d[i];
        pd_q[i]  <= p_q[i] * dv[i];
        ph_q[i]  <= p_q[i] * hv[i];
        pv_q[i]  <= p_q[i] * vv[i];
        dd_q[i]  <= dv[i] * dv[i];
        hh_q[i]  <= hv[i] * hv[i];
        vvq_q[i] <= vv[i] * vv[i];
      end
    end
  end

  // sum into dot products and test the depth
  assign z_s    = DotW'(pd_q[0]) + DotW'(pd_q[1]) + DotW'(pd_q[2]);
  assign len2_s = DotW'(dd_q[0]) + DotW'(dd_q[1]) + DotW'(dd_q[2]);
  assign nu_s   = DotW'(ph_q[0]) + DotW'(ph_q[1]) + DotW'(ph_q[2]);
  assign nv_s   = DotW'(pv_q[0]) + DotW'(pv_q[1]) + DotW'(pv_q[2]);
  assign lu_s   = DotW'(hh_q[0]) + DotW'(hh_q[1]) + DotW'(hh_q[2]);
  assign lv_s   = DotW'(vvq_q[0]) + DotW'(vvq_q[1]) + DotW'(vvq_q[2]);

  assign push_o              = v2_q && adv;
  assign push_data_o.visible = (z_s > len2_s);
  assign push_data_o.num_u   = nu_s;
  assign push_data_o.num_v   = nv_s;
  assign push_data_o.depth   = z_s[MagW-1:0];
  assign push_data_o.len2    = len2_s[LenW-1:0];
  assign push_data_o.len2_u  = lu_s[LenW-1:0];
  assign push_data_o.len2_v  = lv_s[LenW-1:0];

endmodule

`default_nettype wire

[sv/pvp_queue.sv]
// ----------------------------------------------------------------------------
// pvp_queue: short first-in first-out queue between front and back
// Register entries with read and write pointers and a fill count.
// ----------------------------------------------------------------------------
`default_nettype none

module pvp_queue #(
  parameter int DEPTH = pvp_pkg::FifoDepth
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           push_i,
  input  wire pvp_pkg::qent_t push_data_i,
  output logic                full_o,
  input  wire logic           pop_i,
  output logic                nonempty_o,
  output pvp_pkg::qent_t      pop_data_o
);
  import pvp_pkg::*;

  localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntW = $clog2(DEPTH + 1);

  qent_t             mem_q [DEPTH];
  logic [PtrW-1:0]   wr_q, rd_q;
  logic [CntW-1:0]   cnt_q;

  assign full_o     = (cnt_q == CntW'(DEPTH));
  assign nonempty_o = (cnt_q != '0);
  assign pop_data_o = mem_q[rd_q];

  // store the word at the write pointer
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= push_data_i;
    end
  end

  // advance pointers and count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= (wr_q == PtrW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
      end
      if (pop_i) begin
        rd_q <= (rd_q == PtrW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

[sv/pvp_mul.sv]
// ----------------------------------------------------------------------------
// pvp_mul: two-stage wide unsigned multiplier
// Splits both operands in halves, registers four partial products, then sums.
// ----------------------------------------------------------------------------
`default_nettype none

module pvp_mul #(
  parameter int AW = 41,
  parameter int BW = 40
) (
  input  wire logic          clk_i,
  input  wire logic          en_i,
  input  wire logic [AW-1:0] a_i,
  input  wire logic [BW-1:0] b_i,
  output logic [AW+BW-1:0]   p_o
);
  localparam int AL = AW / 2;
  localparam int AH = AW - AL;
  localparam int BL = BW / 2;
  localparam int BH = BW - BL;
  localparam int PW = AW + BW;

  logic [AL+BL-1:0] ll_q;
  logic [AL+BH-1:0] lh_q;
  logic [AH+BL-1:0] hl_q;
  logic [AH+BH-1:0] hh_q;
  logic [PW-1:0]    p_q;

  // partial products, then their weighted sum
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ll_q <= a_i[AL-1:0]  * b_i[BL-1:0];
      lh_q <= a_i[AL-1:0]  * b_i[BW-1:BL];
      hl_q <= a_i[AW-1:AL] * b_i[BL-1:0];
      hh_q <= a_i[AW-1:AL] * b_i[BW-1:BL];
      p_q  <= (PW'(hh_q) << (AL + BL)) + (PW'(lh_q) << BL)
            + (PW'(hl_q) << AL) + PW'(ll_q);
    end
  end

  assign p_o = p_q;

endmodule

`default_nettype wire

[sv/pvp_back.sv]
// ----------------------------------------------------------------------------
// pvp_back: scale, divide and saturate the viewport coordinates
// Magnitude stage, two-stage multipliers, one restoring division stage per
// quotient bit for each coordinate, and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module pvp_back (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           nonempty_i,
  input  wire pvp_pkg::qent_t pop_data_i,
  output logic                pop_o,
  output logic                out_valid_o,
  input  wire logic           out_ready_i,
  output pvp_pkg::proj_t      out_data_o
);
  import pvp_pkg::*;

  localparam int NStg = CoordBits + 3;
  localparam logic [CoordBits-1:0] LimPos = {1'b0, {(CoordBits-1){1'b1}}};
  localparam logic [CoordBits-1:0] LimNeg = {1'b1, {(CoordBits-1){1'b0}}};

  typedef struct packed {
    logic visible;
    logic neg_u;
    logic neg_v;
    logic zero_u;
    logic zero_v;
  } side_t;

  logic en;
  logic out_valid_q;
  proj_t out_q;
  logic  vld_q [NStg];
  side_t side_q [NStg];
  logic [DotW-1:0] abs_u, abs_v;
  logic [MagW-1:0] mag_q [2];
  logic [MagW-1:0] depth_q;
  logic [LenW-1:0] len2_q;
  logic [LenW-1:0] lsq_q [2];
  logic [ProdW-1:0] num_p [2];
  logic [ProdW-1:0] den_p [2];
  logic [DivW-1:0] rem_q [2][CoordBits];
  logic [DivW-1:0] den_q [2][CoordBits];
  logic [CoordBits-1:0] quo_q [2][CoordBits];
  logic ovf_q [2][CoordBits];
  logic [CoordBits-1:0] coord_d [2];

  // move the whole back part while the output register can take a word
  assign en    = !out_valid_q || out_ready_i;
  assign pop_o = en && nonempty_i;

  assign abs_u = pop_data_i.num_u[DotW-1] ? (~pop_data_i.num_u + 1'b1) : pop_data_i.num_u;
  assign abs_v = pop_data_i.num_v[DotW-1] ? (~pop_data_i.num_v + 1'b1) : pop_data_i.num_v;

  // valid and sideband shift along the stages
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NStg; i++) begin
        vld_q[i] <= 1'b0;
      end
    end else if (en) begin
      vld_q[0] <= pop_o;
      for (int i = 1; i < NStg; i++) begin
        vld_q[i] <= vld_q[i-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      side_q[0].visible <= pop_data_i.visible;
      side_q[0].neg_u   <= pop_data_i.num_u[DotW-1];
      side_q[0].neg_v   <= pop_data_i.num_v[DotW-1];
      side_q[0].zero_u  <= (pop_data_i.len2_u == '0);
      side_q[0].zero_v  <= (pop_data_i.len2_v == '0);
      for (int i = 1; i < NStg; i++) begin
        side_q[i] <= side_q[i-1];
      end
      mag_q[0] <= abs_u[MagW-1:0];
      mag_q[1] <= abs_v[MagW-1:0];
      depth_q  <= pop_data_i.depth;
      len2_q   <= pop_data_i.len2;
      lsq_q[0] <= pop_data_i.len2_u;
      lsq_q[1] <= pop_data_i.len2_v;
    end
  end

  genvar l, k;
  generate
    for (l = 0; l < 2; l++) begin : g_lane
      // numerator |num|*|d|^2 and denominator z*|h|^2 (z*|v|^2 in the v lane)
      pvp_mul #(.AW(MagW), .BW(LenW)) u_num (
        .clk_i(clk_i), .en_i(en), .a_i(mag_q[l]), .b_i(len2_q), .p_o(num_p[l])
      );
      pvp_mul #(.AW(MagW), .BW(LenW)) u_den (
        .clk_i(clk_i), .en_i(en), .a_i(depth_q), .b_i(lsq_q[l]), .p_o(den_p[l])
      );

      for (k = 0; k < CoordBits; k++) begin : g_div
        logic [DivW-1:0] rin, din, sub;
        logic [CoordBits-1:0] qin;
        logic oin, take;

        if (k == 0) begin : g_first
          assign rin = DivW'(num_p[l]) << FracBits;
          assign din = DivW'(den_p[l]);
          assign qin = '0;
          assign oin = (rin >= (din << CoordBits));
        end else begin : g_next
          assign rin = rem_q[l][k-1];
          assign din = den_q[l][k-1];
          assign qin = quo_q[l][k-1];
          assign oin = ovf_q[l][k-1];
        end

        // try one quotient bit
        assign sub  = din << (CoordBits - 1 - k);
        assign take = (rin >= sub);

        always_ff @(posedge clk_i) begin
          if (en) begin
            rem_q[l][k] <= take ? (rin - sub) : rin;
            den_q[l][k] <= din;
            quo_q[l][k] <= qin | (CoordBits'(take) << (CoordBits - 1 - k));
            ovf_q[l][k] <= oin;
          end
        end
      end
    end
  endgenerate

  // saturate, restore the sign and zero the coordinates of hidden points and zero-length axes
  always_comb begin
    logic [CoordBits-1:0] lim, q, sat;
    logic neg, zero, ovf;
    for (int i = 0; i < 2; i++) begin
      neg  = (i == 0) ? side_q[NStg-1].neg_u  : side_q[NStg-1].neg_v;
      zero = (i == 0) ? side_q[NStg-1].zero_u : side_q[NStg-1].zero_v;
      q    = quo_q[i][CoordBits-1];
      ovf  = ovf_q[i][CoordBits-1];
      lim  = neg ? LimNeg : LimPos;
      sat  = (ovf || (q > lim)) ? lim : q;
      coord_d[i] = (!side_q[NStg-1].visible || zero) ? '0 : (neg ? (~sat + 1'b1) : sat);
    end
  end

  // hold the result until taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= vld_q[NStg-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_q.visible <= side_q[NStg-1].visible;
      out_q.view_u  <= coord_d[0];
      out_q.view_v  <= coord_d[1];
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire

[sv/pvp_checker.sv]
// ----------------------------------------------------------------------------
// pvp_checker: port-level checks of the viewport projection block
// Watches the top-level ports and is bound to every instance of it.
// ----------------------------------------------------------------------------
`default_nettype none

module pvp_checker (
  input wire logic                         clk_i,
  input wire logic                         rst_ni,
  input wire logic                         in_valid_i,
  input wire logic                         in_ready_o,
  input wire pvp_pkg::point_t              in_data_i,
  input wire logic                         out_valid_o,
  input wire logic                         out_ready_i,
  input wire pvp_pkg::proj_t               out_data_o,
  input wire logic                         psel,
  input wire logic                         penable,
  input wire logic                         pwrite,
  input wire logic [pvp_pkg::AddrBits-1:0] paddr,
  input wire logic [pvp_pkg::DataBits-1:0] pwdata,
  input wire logic [pvp_pkg::DataBits-1:0] prdata,
  input wire logic                         pready
);
  import pvp_pkg::*;

  // no word leaves once reset has been applied
  a_reset_empty: assert property (@(posedge clk_i) !rst_ni |=> !out_valid_o)
    else $error("output word shown during reset");

  // hold a stalled result word
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled output word changed");

  // hidden points carry zero coordinates
  a_hidden_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.visible |-> out_data_o.view_u == '0 && out_data_o.view_v == '0)
    else $error("hidden point with nonzero coordinates");

  // the register port never waits
  a_pready: assert property (@(posedge clk_i) disable iff (!rst_ni) pready)
    else $error("pready dropped");

endmodule

bind perspective_viewport_projection_top pvp_checker u_pvp_checker (.*);

`default_nettype wire

[sim/proj_checker.sv]
// ----------------------------------------------------------------------------
// proj_checker: scoreboard for the viewport projection block
// Tracks camera register writes on the APB port, predicts the projected word
// for every point taken in, and compares each delivered word in order.
// ----------------------------------------------------------------------------
`default_nettype none

module proj_checker (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         in_valid_i,
  input  wire logic                         in_ready_i,
  input  wire pvp_pkg::point_t              in_data_i,
  input  wire logic                         out_valid_i,
  input  wire logic                         out_ready_i,
  input  wire pvp_pkg::proj_t               out_data_i,
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [pvp_pkg::AddrBits-1:0] paddr,
  input  wire logic [pvp_pkg::DataBits-1:0] pwdata,
  input  wire logic                         pready,
  output int                                fail_cnt_o,
  output int                                pending_o
);
  import pvp_pkg::*;

  vec_t   cam_eye, cam_sight, cam_right, cam_up;
  proj_t  proj_q[$];

  // truncated quotient mag*len2*2^FracBits/(z*vv), saturated, signed
  function automatic logic signed [CoordBits-1:0] view_coord(
    longint num, longint len2, longint z, longint vv);
    logic [127:0] n, d, q, lim;
    longint       mag;
    bit           neg;
    if (vv <= 0 || num == 0) return '0;
    neg = num < 0;
    mag = neg ? -num : num;
    n   = mag;
    n   = (n * len2) << FracBits;
    d   = z;
    d   = d * vv;
    q   = n / d;
    lim = neg ? (128'd1 << (CoordBits - 1)) : (128'd1 << (CoordBits - 1)) - 1;
    if (q > lim) q = lim;
    if (neg) q = -q;
    return q[CoordBits-1:0];
  endfunction

  function automatic longint vdot(longint ax, longint ay, longint az,
                                  longint bx, longint by, longint bz);
    return ax * bx + ay * by + az * bz;
  endfunction

  // project one point through the current camera
  function automatic proj_t project(point_t pt);
    proj_t  r;
    longint px, py, pz, depth, len2;
    px    = longint'(pt.point_x) - longint'(cam_eye.x);
    py    = longint'(pt.point_y) - longint'(cam_eye.y);
    pz    = longint'(pt.point_z) - longint'(cam_eye.z);
    depth = vdot(cam_sight.x, cam_sight.y, cam_sight.z, px, py, pz);
    len2  = vdot(cam_sight.x, cam_sight.y, cam_sight.z,
                 cam_sight.x, cam_sight.y, cam_sight.z);
    r = '0;
    if (depth > len2) begin
      r.visible = 1'b1;
      r.view_u  = view_coord(vdot(px, py, pz, cam_right.x, cam_right.y, cam_right.z),
                             len2, depth,
                             vdot(cam_right.x, cam_right.y, cam_right.z,
                                  cam_right.x, cam_right.y, cam_right.z));
      r.view_v  = view_coord(vdot(px, py, pz, cam_up.x, cam_up.y, cam_up.z),
                             len2, depth,
                             vdot(cam_up.x, cam_up.y, cam_up.z,
                                  cam_up.x, cam_up.y, cam_up.z));
    end
    return r;
  endfunction

  // track registers, queue predictions, compare delivered words
  always @(posedge clk_i or negedge rst_ni) begin
    proj_t exp_w;
    if (!rst_ni) begin
      cam_eye    = '0;
      cam_sight  = '{z: 20'sd4096, y: '0, x: '0};
      cam_right  = '{z: '0, y: '0, x: 20'sd4096};
      cam_up     = '{z: '0, y: 20'sd4096, x: '0};
      proj_q.delete();
      fail_cnt_o = 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (cfg_reg_e'(paddr[4:3]))
          RegEye:   cam_eye   = pwdata[RegBits-1:0];
          RegSight: cam_sight = pwdata[RegBits-1:0];
          RegRight: cam_right = pwdata[RegBits-1:0];
          RegUp:    cam_up    = pwdata[RegBits-1:0];
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_i) proj_q.push_back(project(in_data_i));
      if (out_valid_i && out_ready_i) begin
        if (proj_q.size() == 0) begin
          $error("unexpected word delivered: %h", out_data_i);
          fail_cnt_o++;
        end else begin
          exp_w = proj_q.pop_front();
          if (exp_w.visible !== out_data_i.visible) begin
            $error("visible expected %0d got %0d", exp_w.visible, out_data_i.visible);
            fail_cnt_o++;
          end
          if (exp_w.view_u !== out_data_i.view_u) begin
            $error("view_u expected %0d got %0d", exp_w.view_u, out_data_i.view_u);
            fail_cnt_o++;
          end
          if (exp_w.view_v !== out_data_i.view_v) begin
            $error("view_v expected %0d got %0d", exp_w.view_v, out_data_i.view_v);
            fail_cnt_o++;
          end
        end
      end
    end
    pending_o = proj_q.size();
  end

endmodule

`default_nettype wire

[sim/tb.sv]
// ----------------------------------------------------------------------------
// tb: regression bench for the viewport projection block
// Drives points under several camera setups with random idling and one long
// output hold-off; the checker beside the block predicts and compares.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;
  import pvp_pkg::*;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0, in_ready;
  point_t              in_data = '0;
  logic                out_valid, out_ready = 1'b0;
  proj_t               out_data;
  logic                psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [AddrBits-1:0] paddr = '0;
  logic [DataBits-1:0] pwdata = '0, prdata;
  logic                pready;
  int                  fail_cnt, pending;
  int                  n_points = 0, n_phases = 0;
  bit                  calm_in = 1'b0;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  perspective_viewport_projection_top uut (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_ready_o(in_ready), .in_data_i(in_data),
    .out_valid_o(out_valid), .out_ready_i(out_ready), .out_data_o(out_data),
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  proj_checker chk (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_ready_i(in_ready), .in_data_i(in_data),
    .out_valid_i(out_valid), .out_ready_i(out_ready), .out_data_i(out_data),
    .psel, .penable, .pwrite, .paddr, .pwdata, .pready,
    .fail_cnt_o(fail_cnt), .pending_o(pending)
  );

  function automatic logic [DataBits-1:0] pack_vec(int x, int y, int z);
    vec_t w;
    w.x = CoordBits'(x);
    w.y = CoordBits'(y);
    w.z = CoordBits'(z);
    return {4'($urandom_range(15)), w};  // junk above the register width
  endfunction

  function automatic logic [DataBits-1:0] rand_word();
    return {$urandom, $urandom};
  endfunction

  // full range or a few units around the origin
  function automatic point_t rand_point();
    point_t p;
    if ($urandom_range(1)) begin
      p = point_t'(RegBits'({$urandom, $urandom}));
    end else begin
      p.point_x = CoordBits'($signed($urandom_range(65536)) - 32768);
      p.point_y = CoordBits'($signed($urandom_range(65536)) - 32768);
      p.point_z = CoordBits'($signed($urandom_range(65536)) - 32768);
    end
    return p;
  endfunction

  // offer one word; returns at the falling edge after it is taken, valid held
  task automatic send_point(point_t p);
    while (!calm_in && $urandom_range(99) < 35) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= p;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
    n_points++;
  endtask

  task automatic send_xyz(int x, int y, int z);
    point_t p;
    p.point_x = CoordBits'(x);
    p.point_y = CoordBits'(y);
    p.point_z = CoordBits'(z);
    send_point(p);
  endtask

  task automatic reg_write(cfg_reg_e idx, logic [DataBits-1:0] value);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    paddr   <= AddrBits'(idx) << 3;
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // drop valid and let the pipeline drain before touching registers
  task automatic drain();
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (40) @(negedge clk);
  endtask

  task automatic set_camera(logic [DataBits-1:0] e, logic [DataBits-1:0] d,
                            logic [DataBits-1:0] h, logic [DataBits-1:0] v);
    reg_write(RegEye, e);
    reg_write(RegSight, d);
    reg_write(RegRight, h);
    reg_write(RegUp, v);
    n_phases++;
  endtask

  task automatic random_run(int count);
    for (int i = 0; i < count; i++) begin
      calm_in = (i >= 40 && i < 70);
      send_point(rand_point());
    end
    calm_in = 1'b0;
  endtask

  // receiver: random stalls, one long hold-off mid-stream, a calm stretch, then random stalls again
  initial begin
    @(posedge rst_n);
    while (n_points < 100) begin
      @(negedge clk);
      out_ready <= ($urandom_range(99) >= 35);
    end
    repeat (300) begin
      @(negedge clk);
      out_ready <= 1'b0;
    end
    repeat (300) begin
      @(negedge clk);
      out_ready <= 1'b1;
    end
    forever begin
      @(negedge clk);
      out_ready <= ($urandom_range(99) >= 35);
    end
  end

  initial begin
    #(12 * 400000);
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    repeat (7) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // default camera: boundary depth, extremes, signs
    send_xyz(0, 0, 0);
    send_xyz(0, 0, 4096);
    send_xyz(0, 0, 4097);
    send_xyz(4096, 4096, 8192);
    send_xyz(-4096, -4096, 8192);
    send_xyz(524287, 524287, 524287);
    send_xyz(-524288, -524288, 524287);
    send_xyz(-524288, 524287, 4097);
    send_xyz(524287, -524288, 4097);
    send_xyz(0, 0, -524288);
    send_xyz(-524288, -524288, -524288);
    send_xyz(1, -1, 524287);
    send_xyz(100, 200, 4100);
    send_xyz(-1, 1, 8192);
    send_xyz(524287, 0, 8192);
    send_xyz(0, -524288, 12288);
    send_xyz(0, 0, 4095);
    send_xyz(-12345, 54321, 65536);
    random_run(20);
    drain();

    // tiny sight vector: huge scale, saturation
    set_camera(pack_vec(0, 0, 0), pack_vec(0, 0, 1),
               pack_vec(4096, 0, 0), pack_vec(0, 4096, 0));
    send_xyz(524287, -524288, 2);
    send_xyz(-524288, 524287, 2);
    random_run(110);
    drain();

    // zero sight: nothing visible; zero right vector
    set_camera(rand_word(), pack_vec(0, 0, 0), pack_vec(0, 0, 0), rand_word());
    random_run(60);
    drain();

    // extreme components everywhere
    set_camera(pack_vec(-524288, 524287, -524288),
               pack_vec(-524288, -524288, -524288),
               pack_vec(524287, 524287, 524287),
               pack_vec(-524288, -524288, -524288));
    random_run(60);
    drain();

    // fully random cameras
    for (int k = 0; k < 2; k++) begin
      set_camera(rand_word(), rand_word(), rand_word(), rand_word());
      random_run(70);
      drain();
    end

    // small cameras with random content, mostly visible points
    for (int k = 0; k < 3; k++) begin
      set_camera(pack_vec($signed($urandom_range(8192)) - 4096,
                          $signed($urandom_range(8192)) - 4096,
                          $signed($urandom_range(8192)) - 4096),
                 pack_vec($signed($urandom_range(4096)) - 2048,
                          $signed($urandom_range(4096)) - 2048,
                          $urandom_range(8192, 1)),
                 pack_vec($signed($urandom_range(16384)) - 8192,
                          $signed($urandom_range(16384)) - 8192,
                          $signed($urandom_range(16384)) - 8192),
                 pack_vec($signed($urandom_range(16384)) - 8192,
                          $signed($urandom_range(16384)) - 8192,
                          $signed($urandom_range(16384)) - 8192));
      random_run(80);
      drain();
    end

    $display("covered %0d points over %0d camera setups plus reset defaults,",
             n_points, n_phases);
    $display("with random idling on both sides and a long output hold-off");
    if (fail_cnt == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

`default_nettype wire

[sim.f]
sv/pvp_pkg.sv
sv/pvp_front.sv
sv/pvp_queue.sv
sv/pvp_mul.sv
sv/pvp_back.sv
sv/perspective_viewport_projection_top.sv
sv/pvp_checker.sv
sim/proj_checker.sv
sim/tb.sv
